>>> rtl/core/kci_pkg.sv
package kci_pkg;

  localparam int MAX_KEYS_DEF = 16;

  localparam int MODE_W  = 2;
  localparam int IDX_W   = 4;
  localparam int TIME_W  = 17;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 32;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int OFS_W   = TIME_W + 1;
  localparam int PROD_W  = OFS_W + DIFF_W;
  localparam int DEN_W   = TIME_W;
  localparam int QUO_W   = PROD_W + 1;
  localparam int SUM_W   = QUO_W + 1;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int FRAC_W  = 16;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LIN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EASE  = 2'd2;

  localparam logic [TIME_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [TIME_W-1:0] HALF_Q16 = 17'd32768;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK_INC,
    OP_CAP_NEXT,
    OP_CAP_PREV,
    OP_CALC,
    OP_SET_VN,
    OP_MUL_LIN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_FIN_LIN,
    OP_EASE_U,
    OP_EASE_SQ,
    OP_EASE_SC,
    OP_FIN_EASE,
    OP_PUSH
  } kci_op_t;

  typedef struct packed {
    kci_op_t op;
    logic    rd_prev;
  } kci_cmd_t;

  typedef struct packed {
    logic in_eval;
    logic eased;
    logic walk_more;
    logic d_zero;
  } kci_stat_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFF_FFFF);
    lo = SUM_W'(32'sh8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end else begin
      return x[VAL_W-1:0];
    end
  endfunction

endpackage

>>> rtl/core/kci_ram.sv
module kci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/kci_datapath.sv
module kci_datapath
  import kci_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                     clk,
  input  kci_cmd_t                 cmd,
  output kci_stat_t                stat,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [IDX_W-1:0]         in_key_index,
  input  logic [TIME_W-1:0]        in_key_time,
  input  logic signed [VAL_W-1:0]  in_key_value,
  input  logic signed [POS_W-1:0]  in_position,
  input  logic                     in_use_override,
  input  logic signed [VAL_W-1:0]  in_override_value,
  output logic signed [VAL_W-1:0]  out_result_value
);

  localparam int IW = $clog2(MAX_KEYS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_KEYS - 1);
  localparam int RAM_W = TIME_W + VAL_W;

  logic [IW-1:0]              next_r, next_nxt;
  logic [TIME_W-1:0]          pos_r, pos_nxt;
  logic                       eased_r, eased_nxt;
  logic                       ovr_r, ovr_nxt;
  logic signed [VAL_W-1:0]    ovr_val_r, ovr_val_nxt;
  logic [TIME_W-1:0]          tp_r, tp_nxt, tn_r, tn_nxt;
  logic signed [VAL_W-1:0]    vp_r, vp_nxt, vn_r, vn_nxt;
  logic signed [OFS_W-1:0]    d_r, d_nxt, dp_r, dp_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]          num_r, num_nxt;
  logic [DEN_W-1:0]           rem_r, rem_nxt, den_r, den_nxt;
  logic                       neg_r, neg_nxt;
  logic signed [QUO_W-1:0]    q_r, q_nxt;
  logic [TIME_W-1:0]          s_r, s_nxt;
  logic                       lo_r, lo_nxt;
  logic signed [VAL_W-1:0]    res_r, res_nxt;
  logic signed [VAL_W-1:0]    out_r, out_nxt;

  logic                       wr_en;
  logic [IW-1:0]              rd_addr;
  logic [RAM_W-1:0]           rd_data;
  logic [TIME_W-1:0]          rd_time;
  logic signed [VAL_W-1:0]    rd_value;
  logic signed [OFS_W-1:0]    mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   product;
  logic signed [PROD_W-1:0]   dividend;
  logic [OFS_W-1:0]           d_abs;
  logic [DEN_W:0]             trial;
  logic                       ge;
  logic [TIME_W-1:0]          u;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [PROD_W-FRAC_W-1:0] scaled;

  assign wr_en   = (cmd.op == OP_LOAD) && (in_mode == MODE_WRITE) &&
                   (int'(in_key_index) < MAX_KEYS);
  assign rd_addr = cmd.rd_prev ? next_r - IW'(1) : next_r;

  kci_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_KEYS)
  ) u_key_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(IW'(in_key_index)),
    .wdata({in_key_time, in_key_value}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign rd_time  = rd_data[RAM_W-1:VAL_W];
  assign rd_value = rd_data[VAL_W-1:0];

  assign stat.in_eval   = (in_mode == MODE_LIN) || (in_mode == MODE_EASE);
  assign stat.eased     = eased_r;
  assign stat.walk_more = (next_r != LAST_IDX) && (rd_time < pos_r);
  assign stat.d_zero    = (d_r == '0);

  always_comb begin
    case (cmd.op)
      OP_MUL_LIN: begin
        mul_a = dp_r;
        mul_b = diff_r;
      end
      OP_EASE_SQ: begin
        mul_a = signed'({1'b0, s_r});
        mul_b = signed'(DIFF_W'(s_r));
      end
      OP_EASE_SC: begin
        mul_a = signed'(OFS_W'(prod_r[30:15]));
        mul_b = lo_r ? diff_r : -diff_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product  = mul_a * mul_b;
  assign dividend = eased_r ? PROD_W'(dp_r) <<< FRAC_W : prod_r;
  assign d_abs    = d_r[OFS_W-1] ? OFS_W'(-d_r) : OFS_W'(d_r);
  assign trial    = {rem_r, num_r[PROD_W-1]};
  assign ge       = trial >= {1'b0, den_r};

  always_comb begin
    if (q_r < 0) begin
      u = '0;
    end else if (q_r > QUO_W'(signed'({1'b0, ONE_Q16}))) begin
      u = ONE_Q16;
    end else begin
      u = q_r[TIME_W-1:0];
    end
  end

  assign rnd    = prod_r + (prod_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign scaled = rnd[PROD_W-1:FRAC_W];

  always_comb begin
    next_nxt    = next_r;
    pos_nxt     = pos_r;
    eased_nxt   = eased_r;
    ovr_nxt     = ovr_r;
    ovr_val_nxt = ovr_val_r;
    tp_nxt      = tp_r;
    tn_nxt      = tn_r;
    vp_nxt      = vp_r;
    vn_nxt      = vn_r;
    d_nxt       = d_r;
    dp_nxt      = dp_r;
    diff_nxt    = diff_r;
    prod_nxt    = prod_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    neg_nxt     = neg_r;
    q_nxt       = q_r;
    s_nxt       = s_r;
    lo_nxt      = lo_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    case (cmd.op)
      OP_LOAD: begin
        next_nxt    = IW'(1);
        eased_nxt   = (in_mode == MODE_EASE);
        ovr_nxt     = in_use_override;
        ovr_val_nxt = in_override_value;
        res_nxt     = '0;
        if (in_position < 0) begin
          pos_nxt = '0;
        end else if (in_position > POS_W'(ONE_Q16)) begin
          pos_nxt = ONE_Q16;
        end else begin
          pos_nxt = in_position[TIME_W-1:0];
        end
      end
      OP_WALK_INC: next_nxt = next_r + IW'(1);
      OP_CAP_NEXT: begin
        tn_nxt = rd_time;
        vn_nxt = rd_value;
      end
      OP_CAP_PREV: begin
        tp_nxt = rd_time;
        vp_nxt = (ovr_r && (next_r == IW'(1))) ? ovr_val_r : rd_value;
      end
      OP_CALC: begin
        d_nxt    = signed'({1'b0, tn_r}) - signed'({1'b0, tp_r});
        dp_nxt   = signed'({1'b0, pos_r}) - signed'({1'b0, tp_r});
        diff_nxt = DIFF_W'(vn_r) - DIFF_W'(vp_r);
      end
      OP_SET_VN: res_nxt = vn_r;
      OP_MUL_LIN, OP_EASE_SQ, OP_EASE_SC: prod_nxt = product;
      OP_DIV_INIT: begin
        num_nxt = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
        den_nxt = d_abs[DEN_W-1:0];
        rem_nxt = '0;
        neg_nxt = dividend[PROD_W-1] ^ d_r[OFS_W-1];
      end
      OP_DIV_STEP: begin
        rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        num_nxt = {num_r[PROD_W-2:0], ge};
      end
      OP_DIV_END: begin
        q_nxt = neg_r ? -signed'({1'b0, num_r}) : signed'({1'b0, num_r});
      end
      OP_FIN_LIN: res_nxt = sat32(SUM_W'(vp_r) + SUM_W'(q_r));
      OP_EASE_U: begin
        lo_nxt = (u < HALF_Q16);
        s_nxt  = (u < HALF_Q16) ? u : ONE_Q16 - u;
      end
      OP_FIN_EASE: begin
        res_nxt = sat32(SUM_W'(lo_r ? vp_r : vn_r) + SUM_W'(scaled));
      end
      OP_PUSH: out_nxt = res_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    next_r    <= next_nxt;
    pos_r     <= pos_nxt;
    eased_r   <= eased_nxt;
    ovr_r     <= ovr_nxt;
    ovr_val_r <= ovr_val_nxt;
    tp_r      <= tp_nxt;
    tn_r      <= tn_nxt;
    vp_r      <= vp_nxt;
    vn_r      <= vn_nxt;
    d_r       <= d_nxt;
    dp_r      <= dp_nxt;
    diff_r    <= diff_nxt;
    prod_r    <= prod_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    neg_r     <= neg_nxt;
    q_r       <= q_nxt;
    s_r       <= s_nxt;
    lo_r      <= lo_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_result_value = out_r;

endmodule

>>> rtl/core/kci_ctrl.sv
module kci_ctrl
  import kci_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  kci_stat_t stat,
  output kci_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_FETCH_RD,
    S_FETCH_CAP,
    S_CALC,
    S_CHECK,
    S_DIV_INIT,
    S_DIV,
    S_DIV_END,
    S_FIN_LIN,
    S_EASE_U,
    S_EASE_SQ,
    S_EASE_SC,
    S_FIN_EASE,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             push;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign push      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.op      = OP_NONE;
    cmd.rd_prev = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = stat.in_eval ? S_WALK_RD : S_DONE;
        end
      end
      S_WALK_RD: state_nxt = S_WALK_CMP;
      S_WALK_CMP: begin
        if (stat.walk_more) begin
          cmd.op    = OP_WALK_INC;
          state_nxt = S_WALK_RD;
        end else begin
          cmd.op    = OP_CAP_NEXT;
          state_nxt = S_FETCH_RD;
        end
      end
      S_FETCH_RD: begin
        cmd.rd_prev = 1'b1;
        state_nxt   = S_FETCH_CAP;
      end
      S_FETCH_CAP: begin
        cmd.op    = OP_CAP_PREV;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.op    = OP_CALC;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.d_zero) begin
          cmd.op    = OP_SET_VN;
          state_nxt = S_DONE;
        end else begin
          if (!stat.eased) begin
            cmd.op = OP_MUL_LIN;
          end
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd.op    = OP_DIV_END;
        state_nxt = stat.eased ? S_EASE_U : S_FIN_LIN;
      end
      S_FIN_LIN: begin
        cmd.op    = OP_FIN_LIN;
        state_nxt = S_DONE;
      end
      S_EASE_U: begin
        cmd.op    = OP_EASE_U;
        state_nxt = S_EASE_SQ;
      end
      S_EASE_SQ: begin
        cmd.op    = OP_EASE_SQ;
        state_nxt = S_EASE_SC;
      end
      S_EASE_SC: begin
        cmd.op    = OP_EASE_SC;
        state_nxt = S_FIN_EASE;
      end
      S_FIN_EASE: begin
        cmd.op    = OP_FIN_EASE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (push) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/keyframe_curve_interpolator.sv
// Keyframe curve interpolator: table of keyframes, piecewise linear or eased lookup.
// Input channel (in_valid/in_ready) carries one transaction per item: mode 0 writes
// key_time/key_value to slot key_index, mode 1 and 2 evaluate the curve at position
// (linear or quadratic ease), mode 3 does nothing. Every transaction returns exactly
// one result on the output channel (out_valid/out_ready); writes return zero.
// One item is in flight at a time; in_ready is high only while the block is idle,
// so the next item can be accepted at the earliest in the cycle in which out_valid rises.
// The walk visits the keys one at a time, a read state and a compare state per key,
// because the key table has one registered read port; the divider is 51-step bit-serial.
// Results sit in an output register: if the receiver stalls, the next item is
// accepted and processed, and waits for the register before it is delivered.
// Synchronous active-low reset returns the controller to idle with no pending
// transaction; the key table is not cleared and must be written before it is read.
module keyframe_curve_interpolator
  import kci_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [IDX_W-1:0]        in_key_index,
  input  logic [TIME_W-1:0]       in_key_time,
  input  logic signed [VAL_W-1:0] in_key_value,
  input  logic signed [POS_W-1:0] in_position,
  input  logic                    in_use_override,
  input  logic signed [VAL_W-1:0] in_override_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_result_value
);

  kci_cmd_t  cmd;
  kci_stat_t stat;

  kci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kci_datapath #(
    .MAX_KEYS(MAX_KEYS)
  ) u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_key_index     (in_key_index),
    .in_key_time      (in_key_time),
    .in_key_value     (in_key_value),
    .in_position      (in_position),
    .in_use_override  (in_use_override),
    .in_override_value(in_override_value),
    .out_result_value (out_result_value)
  );

endmodule

>>> tb/keyframe_curve_interpolator_checker.sv
module keyframe_curve_interpolator_checker
  import kci_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [IDX_W-1:0]        in_key_index,
  input  logic [TIME_W-1:0]       in_key_time,
  input  logic signed [VAL_W-1:0] in_key_value,
  input  logic signed [POS_W-1:0] in_position,
  input  logic                    in_use_override,
  input  logic signed [VAL_W-1:0] in_override_value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] out_result_value,
  output int                      fail_count,
  output int                      pending
);

  logic [TIME_W-1:0]       key_time_tbl  [MAX_KEYS_DEF];
  logic signed [VAL_W-1:0] key_value_tbl [MAX_KEYS_DEF];
  logic signed [VAL_W-1:0] expected_values [$];
  logic signed [VAL_W-1:0] due_value;

  function automatic logic signed [VAL_W-1:0] clamp_word(input longint x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] curve_value(
    input logic                    eased,
    input logic signed [POS_W-1:0] pos,
    input logic                    ovr,
    input logic signed [VAL_W-1:0] ovr_val
  );
    longint unit;
    longint half;
    longint p;
    longint tp;
    longint tn;
    longint vp;
    longint vn;
    longint d;
    longint u;
    longint w;
    int     lo_key;
    int     hi_key;
    unit = ONE_Q16;
    half = HALF_Q16;
    p = pos;
    if (p < 0) begin
      p = 0;
    end
    if (p > unit) begin
      p = unit;
    end
    lo_key = 0;
    hi_key = 1;
    while (hi_key < MAX_KEYS_DEF - 1 && longint'(key_time_tbl[hi_key]) < p) begin
      lo_key = hi_key;
      hi_key++;
    end
    tp = key_time_tbl[lo_key];
    tn = key_time_tbl[hi_key];
    if (ovr && lo_key == 0) begin
      vp = ovr_val;
    end else begin
      vp = key_value_tbl[lo_key];
    end
    vn = key_value_tbl[hi_key];
    d = tn - tp;
    if (d == 0) begin
      return vn[VAL_W-1:0];
    end
    if (!eased) begin
      return clamp_word(vp + ((p - tp) * (vn - vp)) / d);
    end
    u = ((p - tp) * unit) / d;
    if (u < 0) begin
      u = 0;
    end
    if (u > unit) begin
      u = unit;
    end
    if (u < half) begin
      w = (2 * u * u) / unit;
      return clamp_word(vp + (w * (vn - vp)) / unit);
    end
    w = (2 * (unit - u) * (unit - u)) / unit;
    return clamp_word(vn + (w * (vp - vn)) / unit);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_values.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_mode)
          MODE_WRITE: begin
            if (in_key_index < MAX_KEYS_DEF) begin
              key_time_tbl[in_key_index] = in_key_time;
              key_value_tbl[in_key_index] = in_key_value;
            end
            expected_values.push_back('0);
          end
          MODE_LIN, MODE_EASE: begin
            expected_values.push_back(curve_value(in_mode == MODE_EASE, in_position,
                                                  in_use_override, in_override_value));
          end
          default: begin
            expected_values.push_back('0);
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d", $time,
                   out_result_value);
          fail_count++;
        end else begin
          due_value = expected_values.pop_front();
          if (out_result_value !== due_value) begin
            $display("%0t: result_value mismatch, expected %0d actual %0d", $time,
                     due_value, out_result_value);
            fail_count++;
          end
        end
      end
      pending = expected_values.size();
    end
  end

endmodule

>>> tb/keyframe_curve_interpolator_tb.sv
module keyframe_curve_interpolator_tb;
  import kci_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int STAMP_MAX   = 131071;
  localparam int ITEM_COUNT  = 500;
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [MODE_W-1:0]       in_mode;
  logic [IDX_W-1:0]        in_key_index;
  logic [TIME_W-1:0]       in_key_time;
  logic signed [VAL_W-1:0] in_key_value;
  logic signed [POS_W-1:0] in_position;
  logic                    in_use_override;
  logic signed [VAL_W-1:0] in_override_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_result_value;
  int                      fail_count;
  int                      pending;
  int                      items_sent;
  int                      cycle_count;
  bit                      quiet;

  keyframe_curve_interpolator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_key_index      (in_key_index),
    .in_key_time       (in_key_time),
    .in_key_value      (in_key_value),
    .in_position       (in_position),
    .in_use_override   (in_use_override),
    .in_override_value (in_override_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value)
  );

  keyframe_curve_interpolator_checker curve_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_key_index      (in_key_index),
    .in_key_time       (in_key_time),
    .in_key_value      (in_key_value),
    .in_position       (in_position),
    .in_use_override   (in_use_override),
    .in_override_value (in_override_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    if (quiet) begin
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [TIME_W-1:0] rand_stamp();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_Q16;
      2: return $urandom_range(65537, STAMP_MAX);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_position();
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return '0;
      2: return ONE_Q16;
      3: return -int'($urandom_range(1, 70000));
      4: return int'($urandom_range(65537, 140000));
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic send_item(
    input logic [MODE_W-1:0]       op_mode,
    input logic [IDX_W-1:0]        slot,
    input logic [TIME_W-1:0]       stamp,
    input logic signed [VAL_W-1:0] level,
    input logic signed [POS_W-1:0] pos,
    input logic                    ovr,
    input logic signed [VAL_W-1:0] ovr_level
  );
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode <= op_mode;
    in_key_index <= slot;
    in_key_time <= stamp;
    in_key_value <= level;
    in_position <= pos;
    in_use_override <= ovr;
    in_override_value <= ovr_level;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic store_key(
    input logic [IDX_W-1:0]        slot,
    input logic [TIME_W-1:0]       stamp,
    input logic signed [VAL_W-1:0] level
  );
    send_item(MODE_WRITE, slot, stamp, level, $urandom, $urandom_range(0, 1), $urandom);
  endtask

  task automatic eval_at(
    input logic [MODE_W-1:0]       op_mode,
    input logic signed [POS_W-1:0] pos,
    input logic                    ovr,
    input logic signed [VAL_W-1:0] ovr_level
  );
    send_item(op_mode, $urandom_range(0, 15), $urandom_range(0, STAMP_MAX), $urandom,
              pos, ovr, ovr_level);
  endtask

  task automatic refill_table();
    int stamp;
    int step;
    stamp = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4096);
    for (int k = 0; k < MAX_KEYS_DEF; k++) begin
      store_key(k, ($urandom_range(0, 9) == 0) ? rand_stamp() : stamp, rand_level());
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8192);
      stamp = (stamp + step > STAMP_MAX) ? STAMP_MAX : stamp + step;
    end
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int stall;
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_WRITE;
    in_key_index = '0;
    in_key_time = '0;
    in_key_value = '0;
    in_position = '0;
    in_use_override = 1'b0;
    in_override_value = '0;
    items_sent = 0;
    quiet = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < MAX_KEYS_DEF; k++) begin
      store_key(k, (k == MAX_KEYS_DEF - 1) ? STAMP_MAX : (k == 3) ? 8192 : k * 4096,
                (k == 0) ? 32'sh7FFF_FFFF : (k == 1) ? 32'sh8000_0000 :
                (k[0] ? -k : k) * 32'sh0001_0000);
    end
    eval_at(MODE_LIN, 32'sh8000_0000, 1'b0, '0);
    eval_at(MODE_EASE, 32'sh7FFF_FFFF, 1'b0, '0);
    eval_at(MODE_LIN, ONE_Q16, 1'b0, '0);
    eval_at(MODE_LIN, 2048, 1'b1, 32'sh8000_0000);
    eval_at(MODE_EASE, 3000, 1'b1, 32'sh7FFF_FFFF);
    eval_at(MODE_EASE, 40000, 1'b0, '0);
    eval_at(MODE_NOP, $urandom, 1'b1, $urandom);
    store_key(1, 0, -7);
    eval_at(MODE_LIN, 0, 1'b0, '0);
    eval_at(MODE_EASE, -5, 1'b1, 99);
    store_key(6, 70000, 32'sh4000_0000);
    eval_at(MODE_LIN, 30000, 1'b0, '0);
    eval_at(MODE_EASE, 30000, 1'b0, '0);

    refill_table();
    while (items_sent < ITEM_COUNT) begin
      if ($urandom_range(0, 39) == 0) begin
        quiet = !quiet;
      end
      if ($urandom_range(0, 59) == 0) begin
        refill_table();
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          store_key($urandom_range(0, 15), rand_stamp(), rand_level());
        end else if (pick == 3) begin
          eval_at(MODE_NOP, $urandom, $urandom_range(0, 1), $urandom);
        end else begin
          eval_at((pick < 12) ? MODE_LIN : MODE_EASE, rand_position(),
                  $urandom_range(0, 3) == 0, rand_level());
        end
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
